FILE: sv/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the framed byte deframer
// Holds the queue item format, parser states, status codes, register
// indexes, the probe text and the crc-16/modbus byte update.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ProbeLen  = 21;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEADER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TAIL   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAXLEN = 2'd2;

  // register reset values
  localparam logic [15:0] HEADER_RESET = 16'hA506;
  localparam logic [15:0] TAIL_RESET   = 16'hB607;
  localparam logic [15:0] MAXLEN_RESET = 16'hFFFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // verdict codes
  localparam logic [1:0] ST_OPEN   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_PROBE  = 2'd3;

  // byte plus the front's header and tail compares
  typedef struct packed {
    logic [7:0] data;
    logic       hdr_hi;
    logic       hdr_lo;
    logic       tail_hi;
    logic       tail_lo;
  } cfd_item_t;

  typedef enum logic [3:0] {
    PH_HDR0,
    PH_HDR1,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_TAIL0,
    PH_TAIL1
  } cfd_phase_t;

  // probe text, indexed by payload offset
  function automatic logic [7:0] probe_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h5B; // [
      5'd1:    c = 8'h41; // A
      5'd2:    c = 8'h72; // r
      5'd3:    c = 8'h65; // e
      5'd4:    c = 8'h20;
      5'd5:    c = 8'h79; // y
      5'd6:    c = 8'h6F; // o
      5'd7:    c = 8'h75; // u
      5'd8:    c = 8'h20;
      5'd9:    c = 8'h61; // a
      5'd10:   c = 8'h6E; // n
      5'd11:   c = 8'h20;
      5'd12:   c = 8'h65; // e
      5'd13:   c = 8'h6D; // m
      5'd14:   c = 8'h75; // u
      5'd15:   c = 8'h61; // a
      5'd16:   c = 8'h72; // r
      5'd17:   c = 8'h74; // t
      5'd18:   c = 8'h3F; // ?
      5'd19:   c = 8'h3F; // ?
      5'd20:   c = 8'h5D; // ]
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // crc-16/modbus, one byte, reflected, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/cfd_in_if.sv
// ----------------------------------------------------------------------------
// cfd_in_if: received byte channel
// Valid/ready channel carrying one serial byte per request.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/cfd_out_if.sv
// ----------------------------------------------------------------------------
// cfd_out_if: deframer result channel
// Valid/ready channel carrying one result per received byte.
// ----------------------------------------------------------------------------
interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;

  modport source (
    output valid, output payload_valid, output payload_byte,
    output frame_status, output frame_length, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte,
    input frame_status, input frame_length, output ready
  );
endinterface

FILE: sv/crc_framed_byte_deframer.sv
// A byte accepted on rx is stored in the queue, then taken by the parser, and its result is registered.
// Throughput: one byte per cycle while res.ready stays high; the combinational
// crc byte update and the two-entry queue keep that rate without an rx stall.
// Reset: synchronous rst restores the header, tail and length registers to
// their defaults, empties the queue and returns the parser to idle; rx ready
// stays low while rst is high and no clearing pass is needed.
// ----------------------------------------------------------------------------
// crc_framed_byte_deframer: length-prefixed frame receiver
// Parses header, big-endian length, payload, crc-16/modbus and tail; forwards
// payload bytes and gives a verdict on the last tail byte or on a bad length.
// ----------------------------------------------------------------------------
module crc_framed_byte_deframer
  import cfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  cfd_in_if.sink              rx,
  cfd_out_if.source           res
);

  cfd_item_t   cls_item;
  cfd_item_t   head_item;
  logic [15:0] max_payload;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;

  // front: registers and classification
  cfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .byte_in     (rx.rx_byte),
    .item        (cls_item),
    .max_payload (max_payload)
  );

  assign rx.ready = !q_full && !rst;

  // queue between front and parser
  cfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rx.valid),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // back: parser and result register
  cfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_avail  (q_not_empty),
    .item        (head_item),
    .max_payload (max_payload),
    .item_take   (q_pop),
    .res         (res)
  );

endmodule

FILE: sv/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front: register file and byte classifier
// Holds the configuration registers and tags each incoming byte with its
// header and tail compares before it enters the queue.
// ----------------------------------------------------------------------------
module cfd_front
  import cfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic [7:0]          byte_in,
  output cfd_item_t           item,
  output logic [15:0]         max_payload
);

  logic [15:0] header_word;
  logic [15:0] tail_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= HEADER_RESET;
      tail_word   <= TAIL_RESET;
      max_payload <= MAXLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER: header_word <= cfg_wdata;
        CFG_TAIL:   tail_word   <= cfg_wdata;
        CFG_MAXLEN: max_payload <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // classify the byte
  always_comb begin
    item.data    = byte_in;
    item.hdr_hi  = (byte_in == header_word[15:8]);
    item.hdr_lo  = (byte_in == header_word[7:0]);
    item.tail_hi = (byte_in == tail_word[15:8]);
    item.tail_lo = (byte_in == tail_word[7:0]);
  end

endmodule

FILE: sv/cfd_queue.sv
// ----------------------------------------------------------------------------
// cfd_queue: short queue between classifier and parser
// Small register queue so that the input side and the parser stall apart.
// ----------------------------------------------------------------------------
module cfd_queue
  import cfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cfd_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cfd_item_t head
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cfd_item_t         slots [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back: frame parser and result register
// Walks the frame layout one byte per cycle when not stalled, keeps the crc and
// probe match, and registers one result per byte for the output channel.
// ----------------------------------------------------------------------------
module cfd_back
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_avail,
  input  cfd_item_t   item,
  input  logic [15:0] max_payload,
  output logic        item_take,
  cfd_out_if.source   res
);

  cfd_phase_t  phase, phase_next;
  logic [15:0] len, len_next;
  logic [15:0] off, off_next;
  logic [15:0] crc, crc_next;
  logic        err, err_next;
  logic        probe, probe_next;

  logic        r_pvalid;
  logic [7:0]  r_pbyte;
  logic [1:0]  r_status;
  logic [15:0] r_flen;
  logic [15:0] full_len;
  logic        bad_tail;
  logic        out_valid;

  // take a byte whenever the result register is free or draining
  assign item_take = item_avail && (!out_valid || res.ready);
  assign full_len  = {len[15:8], item.data};
  assign bad_tail  = err || !item.tail_lo;

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      len   <= '0;
      off   <= '0;
      crc   <= CRC_INIT;
      err   <= 1'b0;
      probe <= 1'b1;
    end else if (item_take) begin
      phase <= phase_next;
      len   <= len_next;
      off   <= off_next;
      crc   <= crc_next;
      err   <= err_next;
      probe <= probe_next;
    end
  end

  // next state and result
  always_comb begin
    phase_next = phase;
    len_next   = len;
    off_next   = off;
    crc_next   = crc;
    err_next   = err;
    probe_next = probe;
    r_pvalid   = 1'b0;
    r_pbyte    = 8'h00;
    r_status   = ST_OPEN;
    r_flen     = 16'h0000;
    case (phase)
      PH_HDR0: begin
        if (item.hdr_hi) begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        phase_next = item.hdr_lo ? PH_LEN_HI : PH_HDR0;
      end
      PH_LEN_HI: begin
        len_next   = {item.data, 8'h00};
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (full_len == 16'h0000 || full_len > max_payload) begin
          r_status   = ST_REJECT;
          r_flen     = full_len;
          phase_next = PH_HDR0;
          len_next   = '0;
        end else begin
          len_next   = full_len;
          off_next   = '0;
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r_pvalid = 1'b1;
        r_pbyte  = item.data;
        crc_next = crc_byte(crc, item.data);
        if (len != 16'(ProbeLen) || item.data != probe_char(off[4:0])) begin
          probe_next = 1'b0;
        end
        off_next = off + 16'd1;
        if (off == len - 16'd1) begin
          phase_next = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        if (item.data != crc[15:8]) begin
          err_next = 1'b1;
        end
        phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if (item.data != crc[7:0]) begin
          err_next = 1'b1;
        end
        phase_next = PH_TAIL0;
      end
      PH_TAIL0: begin
        if (!item.tail_hi) begin
          err_next = 1'b1;
        end
        phase_next = PH_TAIL1;
      end
      PH_TAIL1: begin
        if (bad_tail) begin
          r_status = ST_REJECT;
        end else if (len == 16'(ProbeLen) && probe) begin
          r_status = ST_PROBE;
        end else begin
          r_status = ST_ACCEPT;
        end
        r_flen     = len;
        phase_next = PH_HDR0;
        len_next   = '0;
        off_next   = '0;
        crc_next   = CRC_INIT;
        err_next   = 1'b0;
        probe_next = 1'b1;
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res.payload_valid <= r_pvalid;
      res.payload_byte  <= r_pbyte;
      res.frame_status  <= r_status;
      res.frame_length  <= r_flen;
    end
  end

  assign res.valid = out_valid;

endmodule
